@@ sv/crk_pkg.sv @@
// ----------------------------------------------------------------------------
// crk_pkg: shared types and constants of the combination rank iterator
// Action, status, configuration and state codes, the ratio unit's request
// and response structs, and the constant tables for exact small division.
// ----------------------------------------------------------------------------
`default_nettype none

package crk_pkg;

	// Elements the iterator can address; the mask is 32 bits wide.
	localparam int unsigned MAX_ELEMENTS = 32;
	localparam int unsigned MASK_BITS    = 32;
	localparam logic [5:0]  N_CAP        = (MAX_ELEMENTS < MASK_BITS) ?
		6'(MAX_ELEMENTS) : 6'(MASK_BITS);

	// State after reset: 4 of 8, C(8,4) = 70, first combination.
	localparam logic [5:0]  RESET_SET_SIZE = 6'd8;
	localparam logic [5:0]  RESET_CHOOSE   = 6'd4;
	localparam logic [29:0] RESET_TOTAL    = 30'd70;
	localparam logic [31:0] RESET_MASK     = 32'h0000_000F;

	typedef enum logic [2:0] {
		ACT_FIRST     = 3'd0,
		ACT_LAST      = 3'd1,
		ACT_NEXT      = 3'd2,
		ACT_PREV      = 3'd3,
		ACT_SEEK_RANK = 3'd4,
		ACT_SEEK_MASK = 3'd5
	} crk_action_t;

	typedef enum logic [1:0] {
		ST_IN     = 2'd0,
		ST_PAST   = 2'd1,
		ST_BEFORE = 2'd2,
		ST_REJECT = 2'd3
	} crk_status_t;

	typedef enum logic {
		CFG_SET_SIZE = 1'b0,
		CFG_CHOOSE   = 1'b1
	} crk_cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WINIT,
		S_WWAIT,
		S_WSTEP,
		S_EMIT,
		S_TINIT,
		S_TSTEP,
		S_TWAIT
	} crk_state_t;

	typedef enum logic [2:0] {
		D_HOLD,
		D_FIRST,
		D_LAST,
		D_PAST,
		D_BEFORE,
		D_UNRANK,
		D_RANK,
		D_REJECT
	} crk_dec_t;

	// value * mult / div, exact; div in 1..32
	typedef struct packed {
		logic        start;
		logic [29:0] value;
		logic [5:0]  mult;
		logic [5:0]  div;
	} crk_ratio_req_t;

	typedef struct packed {
		logic        done;
		logic [29:0] quot;
	} crk_ratio_rsp_t;

	typedef logic [63:0][29:0] crk_inv_tab_t;
	typedef logic [63:0][2:0]  crk_shift_tab_t;

	// Trailing zeros of a divisor.
	function automatic logic [2:0] div_shift(input int unsigned d);
		int unsigned v;
		logic [2:0]  s;
		v = d;
		s = '0;
		for (int i = 0; i < 5; i++) begin
			if (v != 0 && (v & 1) == 0) begin
				v = v >> 1;
				s = s + 3'd1;
			end
		end
		return s;
	endfunction

	// Inverse of the divisor's odd part modulo 2^30 (Newton iteration).
	function automatic logic [29:0] div_inverse(input int unsigned d);
		int unsigned v;
		logic [29:0] x;
		logic [29:0] ox;
		logic [29:0] t;
		v = d;
		for (int i = 0; i < 5; i++) begin
			if (v != 0 && (v & 1) == 0) begin
				v = v >> 1;
			end
		end
		x = 30'(v);
		for (int i = 0; i < 5; i++) begin
			ox = 30'(v) * x;
			t  = 30'd2 - ox;
			x  = x * t;
		end
		return x;
	endfunction

	function automatic crk_inv_tab_t build_inv();
		crk_inv_tab_t tab;
		for (int d = 0; d < 64; d++) begin
			tab[d] = div_inverse(unsigned'(d));
		end
		return tab;
	endfunction

	function automatic crk_shift_tab_t build_shift();
		crk_shift_tab_t tab;
		for (int d = 0; d < 64; d++) begin
			tab[d] = div_shift(unsigned'(d));
		end
		return tab;
	endfunction

	localparam crk_inv_tab_t   DIV_INV   = build_inv();
	localparam crk_shift_tab_t DIV_SHIFT = build_shift();

endpackage

`default_nettype wire

@@ sv/crk_if.sv @@
// ----------------------------------------------------------------------------
// crk_if: item and result channels of the combination rank iterator
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface crk_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [29:0] rank_in;
	logic [31:0] mask_in;

	modport source (output valid, action, rank_in, mask_in, input ready);
	modport sink   (input valid, action, rank_in, mask_in, output ready);
endinterface

interface crk_result_if;
	logic        valid;
	logic        ready;
	logic [29:0] rank_out;
	logic [31:0] mask_out;
	logic [29:0] total;
	logic [1:0]  status;

	modport source (output valid, rank_out, mask_out, total, status, input ready);
	modport sink   (input valid, rank_out, mask_out, total, status, output ready);
endinterface

`default_nettype wire

@@ sv/crk_ratio_unit.sv @@
// ----------------------------------------------------------------------------
// crk_ratio_unit: shared multiply and exact small divide
// Computes value * mult / div on one multiplier; the division
// is exact, so it is a shift by the divisor's trailing zeros and a multiply
// by the inverse of its odd part modulo 2^30.
// ----------------------------------------------------------------------------
`default_nettype none

module crk_ratio_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  crk_pkg::crk_ratio_req_t  req,
	output crk_pkg::crk_ratio_rsp_t  rsp
);
	import crk_pkg::*;

	logic        phase_q;
	logic        done_q;
	logic [35:0] prod_q;
	logic [5:0]  div_q;
	logic [29:0] quot_q;

	logic [35:0] shifted;
	logic [29:0] mul_a;
	logic [29:0] mul_b;
	logic [59:0] mul_p;

	assign shifted = prod_q >> DIV_SHIFT[div_q];

	// first pass: product; second pass: exact quotient
	always_comb begin
		if (phase_q) begin
			mul_a = shifted[29:0];
			mul_b = DIV_INV[div_q];
		end else begin
			mul_a = req.value;
			mul_b = {24'd0, req.mult};
		end
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= req.start;
			done_q  <= phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= mul_p[35:0];
			div_q  <= req.div;
		end
		if (phase_q) begin
			quot_q <= mul_p[29:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

@@ sv/combination_rank_iterator_top.sv @@
// ----------------------------------------------------------------------------
// combination_rank_iterator_top: k-of-n combination iterator in colex order
// First, last, hold and out-of-range cases go from decode straight to the
//   result register; step and seek actions walk positions n-1 down to the
//   lowest chosen one.
// Throughput: one item at a time; the walk is bound by the shared ratio unit.
// A configuration write keeps the block busy while it recounts the total.
// Reset: n = 8, k = 4, total 70, first combination (rank 0, mask 0xF).
// ----------------------------------------------------------------------------
`default_nettype none

module combination_rank_iterator_top (
	input  logic         clk,
	input  logic         arst_n,
	crk_item_if.sink     item,
	crk_result_if.source result,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [5:0]   cfg_data
);
	import crk_pkg::*;

	// Count set bits: nibble counts, then a short sum.
	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [7:0][2:0] nib;
		logic [5:0]      sum;
		for (int g = 0; g < 8; g++) begin
			nib[g] = 3'(v[4*g]) + 3'(v[4*g+1]) + 3'(v[4*g+2]) + 3'(v[4*g+3]);
		end
		sum = '0;
		for (int g = 0; g < 8; g++) begin
			sum = sum + 6'(nib[g]);
		end
		return sum;
	endfunction

	function automatic logic [31:0] low_mask(input logic [5:0] cnt);
		logic [31:0] m;
		for (int i = 0; i < 32; i++) begin
			m[i] = (6'(i) < cnt);
		end
		return m;
	endfunction

	// ---------------- state ----------------
	crk_state_t  state_q, state_d;

	// configuration and architectural state
	logic [5:0]  set_size_q;
	logic [5:0]  choose_q;
	logic [29:0] total_q;
	logic [29:0] rank_q;
	logic [31:0] mask_q;
	crk_status_t range_q;

	// latched item
	logic [2:0]  act_q;
	logic [29:0] rin_q;
	logic [31:0] min_q;

	// walk registers: position, remaining k, current binomial, accumulator
	logic [5:0]  pos_q;
	logic [5:0]  kk_q;
	logic [29:0] c_q;
	logic [29:0] acc_q;
	logic [29:0] tgt_q;
	logic [5:0]  excess_q;
	logic [31:0] wmask_q;
	logic        rank_mode_q;
	logic        reject_q;

	// total count loop
	logic [5:0]  ti_q;
	logic [5:0]  tkm_q;

	// output register
	logic        out_valid_q;
	logic [29:0] out_rank_q;
	logic [31:0] out_mask_q;
	logic [29:0] out_total_q;
	crk_status_t out_status_q;

	crk_ratio_req_t ratio_req;
	crk_ratio_rsp_t ratio_rsp;

	crk_ratio_unit u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ratio_req),
		.rsp    (ratio_rsp)
	);

	// ---------------- common terms ----------------
	logic [5:0]  n_eff;
	logic        k_over;
	logic        tot_zero;
	logic [31:0] first_mask;
	logic [31:0] last_mask;
	logic [5:0]  cnt;
	logic [30:0] rank_inc;
	logic        load_out;

	// clamp n to what the element range and mask allow
	assign n_eff      = (set_size_q > N_CAP) ? N_CAP : set_size_q;
	assign k_over     = choose_q > n_eff;
	assign tot_zero   = (total_q == '0);
	assign first_mask = low_mask(choose_q);
	assign last_mask  = low_mask(n_eff) & ~low_mask(n_eff - choose_q);
	assign cnt        = popcount32(min_q & low_mask(n_eff));
	assign rank_inc   = {1'b0, rank_q} + 31'd1;

	// ---------------- action decode ----------------
	crk_dec_t    dec_op;
	logic [29:0] dec_target;

	always_comb begin
		dec_op     = D_HOLD;
		dec_target = '0;
		case (act_q)
			ACT_FIRST: begin
				dec_op = tot_zero ? D_PAST : D_FIRST;
			end
			ACT_LAST: begin
				dec_op = tot_zero ? D_PAST : D_LAST;
			end
			ACT_NEXT: begin
				// past end holds; before begin repairs to first
				if (range_q == ST_PAST) begin
					dec_op = D_HOLD;
				end else if (range_q == ST_BEFORE) begin
					dec_op = tot_zero ? D_PAST : D_FIRST;
				end else if (rank_inc >= {1'b0, total_q}) begin
					dec_op = D_PAST;
				end else begin
					dec_op     = D_UNRANK;
					dec_target = rank_inc[29:0];
				end
			end
			ACT_PREV: begin
				// before begin holds; past end repairs to last
				if (range_q == ST_BEFORE) begin
					dec_op = D_HOLD;
				end else if (range_q == ST_PAST) begin
					dec_op = tot_zero ? D_PAST : D_LAST;
				end else if (rank_q == '0) begin
					dec_op = D_BEFORE;
				end else begin
					dec_op     = D_UNRANK;
					dec_target = rank_q - 30'd1;
				end
			end
			ACT_SEEK_RANK: begin
				if (rin_q >= total_q) begin
					dec_op = D_PAST;
				end else begin
					dec_op     = D_UNRANK;
					dec_target = rin_q;
				end
			end
			ACT_SEEK_MASK: begin
				// too few usable bits or no combinations: reject and leave the state alone
				dec_op = (cnt < choose_q || tot_zero) ? D_REJECT : D_RANK;
			end
			default: begin
				dec_op = D_HOLD;
			end
		endcase
	end

	// ---------------- walk step ----------------
	// Positions go from n-1 down; c_q holds C(pos, kk). Unranking takes a
	// position when its binomial fits the remaining rank; ranking takes the
	// lowest k set bits, skipping the surplus from the top.
	logic        wbit;
	logic        take;
	logic [5:0]  kk_next;
	logic [29:0] acc_next;
	logic [31:0] wmask_next;
	logic        walk_end;

	assign wbit       = min_q[pos_q[4:0]];
	assign take       = rank_mode_q ? (wbit && excess_q == '0) : (c_q <= acc_q);
	assign kk_next    = take ? kk_q - 6'd1 : kk_q;
	assign acc_next   = take ? (rank_mode_q ? acc_q + c_q : acc_q - c_q) : acc_q;
	assign wmask_next = take ? (wmask_q | (32'd1 << pos_q[4:0])) : wmask_q;
	assign walk_end   = (kk_next == '0) || (pos_q == '0);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		ratio_req.start = 1'b0;
		ratio_req.value = c_q;
		ratio_req.mult  = '0;
		ratio_req.div   = pos_q;
		case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (dec_op == D_UNRANK || dec_op == D_RANK) begin
					state_d = S_WINIT;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_WINIT: begin
				// C(n-1,k) = C(n,k) * (n-k) / n
				if (kk_q == '0) begin
					state_d = S_EMIT;
				end else begin
					ratio_req.start = 1'b1;
					ratio_req.value = total_q;
					ratio_req.mult  = pos_q - kk_q;
					state_d         = S_WWAIT;
				end
			end
			S_WWAIT: begin
				if (ratio_rsp.done) begin
					state_d = S_WSTEP;
				end
			end
			S_WSTEP: begin
				// taken: C(p-1,kk-1) = C(p,kk)*kk/p, else C(p-1,kk) = C(p,kk)*(p-kk)/p
				if (walk_end) begin
					state_d = S_EMIT;
				end else begin
					ratio_req.start = 1'b1;
					ratio_req.mult  = take ? kk_q : pos_q - kk_q;
					state_d         = S_WWAIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || result.ready) begin
					state_d = S_IDLE;
				end
			end
			S_TINIT: begin
				state_d = k_over ? S_IDLE : S_TSTEP;
			end
			S_TSTEP: begin
				// C(n,i+1) = C(n,i) * (n-i) / (i+1)
				if (ti_q == tkm_q) begin
					state_d = S_IDLE;
				end else begin
					ratio_req.start = !cfg_we;
					ratio_req.mult  = n_eff - ti_q;
					ratio_req.div   = ti_q + 6'd1;
					state_d         = S_TWAIT;
				end
			end
			S_TWAIT: begin
				if (ratio_rsp.done) begin
					state_d = S_TSTEP;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// a register write restarts the count
		if (cfg_we) begin
			state_d = S_TINIT;
		end
	end

	assign item.ready = (state_q == S_IDLE);

	// ---------------- architectural state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= RESET_SET_SIZE;
			choose_q   <= RESET_CHOOSE;
			total_q    <= RESET_TOTAL;
			rank_q     <= '0;
			mask_q     <= RESET_MASK;
			range_q    <= ST_IN;
		end else begin
			if (cfg_we) begin
				case (crk_cfg_idx_t'(cfg_index))
					CFG_SET_SIZE: set_size_q <= cfg_data;
					CFG_CHOOSE:   choose_q   <= cfg_data;
					default:      ;
				endcase
			end
			case (state_q)
				S_DECODE: begin
					case (dec_op)
						D_FIRST: begin
							rank_q  <= '0;
							mask_q  <= first_mask;
							range_q <= ST_IN;
						end
						D_LAST: begin
							rank_q  <= total_q - 30'd1;
							mask_q  <= last_mask;
							range_q <= ST_IN;
						end
						D_PAST: begin
							rank_q  <= total_q;
							mask_q  <= '0;
							range_q <= ST_PAST;
						end
						D_BEFORE: begin
							rank_q  <= '0;
							mask_q  <= '0;
							range_q <= ST_BEFORE;
						end
						default: ;
					endcase
				end
				S_WINIT: begin
					// k = 0: the single empty combination
					if (kk_q == '0) begin
						rank_q  <= rank_mode_q ? acc_q : tgt_q;
						mask_q  <= wmask_q;
						range_q <= ST_IN;
					end
				end
				S_WSTEP: begin
					if (walk_end) begin
						rank_q  <= rank_mode_q ? acc_next : tgt_q;
						mask_q  <= wmask_next;
						range_q <= ST_IN;
					end
				end
				S_TINIT: begin
					// k above n: no combinations, park past end
					if (k_over) begin
						total_q <= '0;
						rank_q  <= '0;
						mask_q  <= '0;
						range_q <= ST_PAST;
					end
				end
				S_TSTEP: begin
					if (ti_q == tkm_q) begin
						total_q <= c_q;
						rank_q  <= '0;
						mask_q  <= first_mask;
						range_q <= ST_IN;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			act_q <= item.action;
			rin_q <= item.rank_in;
			min_q <= item.mask_in;
		end
		case (state_q)
			S_DECODE: begin
				reject_q    <= (dec_op == D_REJECT);
				pos_q       <= n_eff;
				kk_q        <= choose_q;
				wmask_q     <= '0;
				tgt_q       <= dec_target;
				rank_mode_q <= (dec_op == D_RANK);
				acc_q       <= (dec_op == D_RANK) ? '0 : dec_target;
				excess_q    <= cnt - choose_q;
			end
			S_WWAIT: begin
				// advance to the next lower position
				if (ratio_rsp.done) begin
					c_q   <= ratio_rsp.quot;
					pos_q <= pos_q - 6'd1;
				end
			end
			S_WSTEP: begin
				kk_q    <= kk_next;
				acc_q   <= acc_next;
				wmask_q <= wmask_next;
				// drop surplus set bits above the lowest k
				if (rank_mode_q && wbit && excess_q != '0) begin
					excess_q <= excess_q - 6'd1;
				end
			end
			S_TINIT: begin
				// C(n,k) = C(n,n-k): run the shorter product
				c_q   <= 30'd1;
				ti_q  <= '0;
				tkm_q <= (choose_q < n_eff - choose_q) ? choose_q : n_eff - choose_q;
			end
			S_TWAIT: begin
				if (ratio_rsp.done) begin
					c_q  <= ratio_rsp.quot;
					ti_q <= ti_q + 6'd1;
				end
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	// Hold the result until taken; the next item may be accepted meanwhile.
	assign load_out = (state_q == S_EMIT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rank_q   <= rank_q;
			out_mask_q   <= mask_q;
			out_total_q  <= total_q;
			out_status_q <= reject_q ? ST_REJECT : range_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.rank_out = out_rank_q;
	assign result.mask_out = out_mask_q;
	assign result.total    = out_total_q;
	assign result.status   = out_status_q;

endmodule

`default_nettype wire

@@ sv/crk_checker.sv @@
// ----------------------------------------------------------------------------
// crk_checker: port-level checks of the combination rank iterator
// Watches the channels and the register port; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module crk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [29:0] rank_out,
	input logic [31:0] mask_out,
	input logic [29:0] total,
	input logic [1:0]  status,
	input logic        cfg_we
);
	import crk_pkg::*;

	// one item at a time: busy right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous item still in work");

	// a register write starts the count and blocks items
	a_busy_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !item_ready)
		else $error("item port ready right after register write");

	// past end shows rank equal to total and an empty mask
	a_past_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_PAST |-> rank_out == total && mask_out == '0)
		else $error("past-end result with wrong rank or mask");

	// in range ranks stay below the count
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_IN |-> rank_out < total)
		else $error("in-range result with rank at or above total");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(rank_out)
			&& $stable(mask_out) && $stable(status))
		else $error("stalled result changed");

endmodule

bind combination_rank_iterator_top crk_checker u_crk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.rank_out     (result.rank_out),
	.mask_out     (result.mask_out),
	.total        (result.total),
	.status       (result.status),
	.cfg_we       (cfg_we)
);

`default_nettype wire
